@@ sv/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared widths, register indexes and the divider word type for the
// photometric pixel correction block.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int PIXEL_BITS_DEF = 16;
    localparam int RAW_BITS       = 16;
    localparam int GAIN_BITS      = 16;
    localparam int BASE_BITS      = 24;
    localparam int OUT_BITS       = 32;
    localparam int FRAC_SHIFT     = 15;
    localparam int DIV_STEPS      = OUT_BITS;
    // Bits of the base that land above the 32-bit quotient after the shift.
    localparam int OVF_LSB        = OUT_BITS - FRAC_SHIFT;

    localparam int S_TDATA_BITS   = 56;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RESPONSE_ENABLED   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VIGNETTING_ENABLED = 8'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                 bypass;
        logic                 sat;
        logic [BASE_BITS-1:0] base;
    } ppc_tag_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0] gain;
        logic [GAIN_BITS-1:0] rem;
        logic [OUT_BITS-1:0]  quo;
        ppc_tag_t             tag;
    } ppc_div_word_t;

endpackage

@@ sv/ppc_ram.sv @@
// ----------------------------------------------------------------------------
// ppc_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ppc_div_pipe.sv @@
// ----------------------------------------------------------------------------
// ppc_div_pipe
// Restoring divider, one quotient bit per pipeline stage. Each stage holds
// when it is full and the stage after it cannot take its word, so bubbles
// are squeezed out while the output stalls.
// ----------------------------------------------------------------------------
module ppc_div_pipe
    import ppc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ppc_div_word_t in_word,
    output logic          out_valid,
    input  logic          out_ready,
    output ppc_div_word_t out_word
);

    function automatic ppc_div_word_t div_step(input ppc_div_word_t w);
        ppc_div_word_t r;
        logic [GAIN_BITS:0] trial;
        r     = w;
        trial = {w.rem, w.quo[OUT_BITS-1]};
        if (trial >= {1'b0, w.gain}) begin
            r.rem = GAIN_BITS'(trial - {1'b0, w.gain});
            r.quo = {w.quo[OUT_BITS-2:0], 1'b1};
        end else begin
            r.rem = trial[GAIN_BITS-1:0];
            r.quo = {w.quo[OUT_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    logic          valid_reg [DIV_STEPS];
    ppc_div_word_t word_reg  [DIV_STEPS];
    logic          en        [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
        logic          prev_valid;
        ppc_div_word_t prev_word;

        if (i == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_word  = in_word;
        end else begin : g_next
            assign prev_valid = valid_reg[i-1];
            assign prev_word  = word_reg[i-1];
        end

        if (i == DIV_STEPS - 1) begin : g_last_en
            assign en[i] = !valid_reg[i] || out_ready;
        end else begin : g_mid_en
            assign en[i] = !valid_reg[i] || en[i+1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en[i]) begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[i]) begin
                word_reg[i] <= div_step(prev_word);
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_word  = word_reg[DIV_STEPS-1];

endmodule

@@ sv/photometric_pixel_correction.sv @@
// ----------------------------------------------------------------------------
// photometric_pixel_correction
// A pixel word passes from the table read at the edge that accepts it through
// operand setup, 32 divider stages and the output register to m_tdata.
// Throughput: one word per cycle while m_tready does not hold the output;
// the 32-stage pipelined divider sets the depth.
// Table-write words give no output word.
// Reset clears the pipeline valids and both enables; the table is not cleared.
// ----------------------------------------------------------------------------
module photometric_pixel_correction
    import ppc_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Fields from bit 0: raw_intensity[15:0], vignette_factor[31:16],
    // table_word[55:32].
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_TDATA_BITS-1:0]   s_tdata,
    // Fields from bit 0: command.
    input  logic                      s_tuser,
    // Fields from bit 0: corrected_intensity[31:0].
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_BITS-1:0]       m_tdata,
    // Fields from bit 0: saturated.
    output logic                      m_tuser,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int DEPTH = 1 << PIXEL_BITS;

    logic resp_en_reg;
    logic vig_en_reg;

    logic                  st1_valid_reg;
    logic [PIXEL_BITS-1:0] st1_pix_reg;
    logic [GAIN_BITS-1:0]  st1_gain_reg;
    logic                  st1_en;

    logic                  st2_valid_reg;
    ppc_div_word_t         st2_word_reg;
    ppc_div_word_t         st2_word_next;
    logic                  st2_en;

    logic                  s_cmd;
    logic [PIXEL_BITS-1:0] s_pix;
    logic [GAIN_BITS-1:0]  s_gain;
    logic [BASE_BITS-1:0]  s_word;
    logic [BASE_BITS-1:0]  ram_rdata;

    logic                  div_in_ready;
    logic                  div_out_valid;
    logic                  div_out_ready;
    ppc_div_word_t         div_out_word;

    logic                  m_tvalid_reg;
    logic [OUT_BITS-1:0]   m_tdata_reg;
    logic                  m_tuser_reg;
    logic [OUT_BITS-1:0]   m_tdata_next;
    logic                  m_tuser_next;

    assign s_cmd  = s_tuser;
    assign s_pix  = s_tdata[PIXEL_BITS-1:0];
    assign s_gain = s_tdata[RAW_BITS +: GAIN_BITS];
    assign s_word = s_tdata[RAW_BITS+GAIN_BITS +: BASE_BITS];

    // Configuration registers; writes to other indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resp_en_reg <= 1'b0;
            vig_en_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_RESPONSE_ENABLED) begin
                resp_en_reg <= cfg_data[0];
            end
            if (cfg_index == REG_VIGNETTING_ENABLED) begin
                vig_en_reg <= cfg_data[0];
            end
        end
    end

    // Stage 1: table access. The RAM output register is part of this stage,
    // so it only advances together with the stage.
    assign st1_en   = !st1_valid_reg || st2_en;
    assign s_tready = st1_en;

    ppc_ram #(
        .WIDTH (BASE_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .en    (st1_en),
        .we    (s_tvalid && s_cmd == CMD_WRITE),
        .addr  (s_pix),
        .wdata (s_word),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (st1_en) begin
            st1_valid_reg <= s_tvalid && s_cmd == CMD_PIXEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_en) begin
            st1_pix_reg  <= s_pix;
            st1_gain_reg <= s_gain;
        end
    end

    // Stage 2: pick the base value and set up the divider operands.
    always_comb begin
        logic [BASE_BITS-1:0] base;
        logic                 zero_gain;
        logic                 overflow;
        base = resp_en_reg ? ram_rdata : BASE_BITS'({st1_pix_reg, 8'h00});
        zero_gain = st1_gain_reg == '0;
        // The quotient exceeds 32 bits exactly when the part of the shifted
        // base above bit 31 already reaches the divisor.
        overflow = GAIN_BITS'(base[BASE_BITS-1:OVF_LSB]) >= st1_gain_reg;
        st2_word_next.gain       = st1_gain_reg;
        st2_word_next.rem        = GAIN_BITS'(base[BASE_BITS-1:OVF_LSB]);
        st2_word_next.quo        = {base[OVF_LSB-1:0], FRAC_SHIFT'(0)};
        st2_word_next.tag.bypass = !vig_en_reg;
        st2_word_next.tag.sat    = zero_gain || overflow;
        st2_word_next.tag.base   = base;
    end

    assign st2_en = !st2_valid_reg || div_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (st2_en) begin
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st2_en) begin
            st2_word_reg <= st2_word_next;
        end
    end

    ppc_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st2_valid_reg),
        .in_ready  (div_in_ready),
        .in_word   (st2_word_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_word  (div_out_word)
    );

    // Output register.
    assign div_out_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        if (div_out_word.tag.bypass) begin
            m_tdata_next = OUT_BITS'(div_out_word.tag.base);
            m_tuser_next = 1'b0;
        end else if (div_out_word.tag.sat) begin
            m_tdata_next = '1;
            m_tuser_next = 1'b1;
        end else begin
            m_tdata_next = div_out_word.quo;
            m_tuser_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (div_out_ready) begin
            m_tvalid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_out_ready) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_sat_is_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '1)
        else $error("saturated word without full-scale value");

    a_no_sat_when_bypassed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !vig_en_reg |-> !m_tuser)
        else $error("saturation flagged with vignetting disabled");

    a_passthrough_frac_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !vig_en_reg && !resp_en_reg |-> m_tdata[7:0] == 8'h00)
        else $error("raw passthrough has nonzero fraction bits");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == CMD_WRITE |=> !st1_valid_reg)
        else $error("table write entered the pixel pipeline");
`endif

endmodule

@@ dv/photometric_pixel_correction_test.sv @@
// ----------------------------------------------------------------------------
// photometric_pixel_correction_test
// Self-checking bench for the photometric pixel correction block. Table-write
// and pixel words go through the input stream in random bursts. Each accepted
// pixel word is corrected by a model in the bench, and the result is queued.
// Output words leave under random back-pressure and are checked field by field
// against that queue. The enables change only while the block is idle.
// ----------------------------------------------------------------------------
module photometric_pixel_correction_test;
    import ppc_pkg::*;

    localparam int PIPE_LATENCY   = 34;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_HALF    = 55;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LOW  = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_HIGH = 8'hFF;

    typedef struct packed {
        logic                 cmd;
        logic [RAW_BITS-1:0]  raw;
        logic [GAIN_BITS-1:0] gain;
        logic [BASE_BITS-1:0] word;
    } stream_word_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                sat;
    } correction_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata   = '0;
    logic                      s_tuser   = CMD_PIXEL;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_BITS-1:0]       m_tdata;
    logic                      m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Bench copy of the block state.
    logic [BASE_BITS-1:0] response_words [0:(1 << RAW_BITS) - 1];
    bit                   lut_on;
    bit                   vig_on;

    stream_word_t pending_words[$];
    correction_t  expected_corrections[$];
    logic [RAW_BITS-1:0] loaded_addrs[$];

    stream_word_t cur_word;
    int           burst_left     = 1;
    int           gap_left       = 0;
    bit           steady_sender  = 1'b0;
    logic [31:0]  stall_bits     = '1;
    int           stall_epoch    = 0;
    int           idle_cycles    = 0;
    int           mismatch_count = 0;
    int           pixel_count    = 0;
    int           write_count    = 0;
    int           sat_count      = 0;
    int           settings_count = 0;

    photometric_pixel_correction dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic correction_t correct_pixel(logic [RAW_BITS-1:0] raw,
                                                  logic [GAIN_BITS-1:0] gain);
        correction_t          res;
        logic [BASE_BITS-1:0] base;
        logic [63:0]          quot;
        base = lut_on ? response_words[raw] : {raw, 8'h00};
        res.value = OUT_BITS'(base);
        res.sat   = 1'b0;
        if (vig_on) begin
            if (gain == '0) begin
                res.value = '1;
                res.sat   = 1'b1;
            end else begin
                quot = ({40'd0, base} << FRAC_SHIFT) / {48'd0, gain};
                if (quot[63:32] != '0) begin
                    res.value = '1;
                    res.sat   = 1'b1;
                end else begin
                    res.value = quot[31:0];
                end
            end
        end
        return res;
    endfunction

    function automatic void report_mismatch(string what, logic [OUT_BITS-1:0] want,
                                            logic [OUT_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
    endfunction

    // Driver: bursts of words with random gaps, a word held until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (cur_word.cmd == CMD_WRITE) begin
                    response_words[cur_word.raw] = cur_word.word;
                    write_count++;
                end else begin
                    expected_corrections.push_back(correct_pixel(cur_word.raw, cur_word.gain));
                    pixel_count++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_word.word, cur_word.gain, cur_word.raw};
                    s_tuser  <= cur_word.cmd;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = (steady_sender || $urandom_range(0, 3) == 0) ?
                                     0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks output words and stalls the result side on its own pattern.
    always @(posedge aclk) begin
        correction_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_corrections.size() == 0) begin
                    report_mismatch("unexpected output word", '0, m_tdata);
                end else begin
                    want = expected_corrections.pop_front();
                    if (want.sat)
                        sat_count++;
                    if (m_tdata !== want.value)
                        report_mismatch("corrected_intensity", want.value, m_tdata);
                    if (m_tuser !== want.sat)
                        report_mismatch("saturated", OUT_BITS'(want.sat), OUT_BITS'(m_tuser));
                end
            end
            if (stall_epoch == 0) begin
                stall_epoch = 32;
                case ($urandom_range(0, 3))
                    0:       stall_bits = '1;
                    1:       stall_bits = $urandom() | $urandom();
                    2:       stall_bits = $urandom();
                    default: stall_bits = $urandom() & $urandom();
                endcase
            end
            stall_epoch--;
            m_tready   <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[31:1]};
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("photometric_pixel_correction_test: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_RESPONSE_ENABLED)
            lut_on = data[0];
        else if (index == REG_VIGNETTING_ENABLED)
            vig_on = data[0];
    endtask

    task automatic wait_results();
        while (pending_words.size() != 0 || s_tvalid || expected_corrections.size() != 0)
            @(posedge aclk);
    endtask

    // Table writes give no output word, so the pipe is let run empty as well.
    task automatic apply_settings(bit lut, bit vig);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_RESPONSE_ENABLED, lut);
        write_reg(REG_VIGNETTING_ENABLED, vig);
        settings_count++;
    endtask

    function automatic void push_write(logic [RAW_BITS-1:0] addr, logic [BASE_BITS-1:0] word);
        stream_word_t w;
        w.cmd  = CMD_WRITE;
        w.raw  = addr;
        w.gain = GAIN_BITS'($urandom());
        w.word = word;
        pending_words.push_back(w);
        loaded_addrs.push_back(addr);
    endfunction

    function automatic void push_pixel(logic [RAW_BITS-1:0] raw, logic [GAIN_BITS-1:0] gain);
        stream_word_t w;
        w.cmd  = CMD_PIXEL;
        w.raw  = raw;
        w.gain = gain;
        w.word = BASE_BITS'($urandom());
        pending_words.push_back(w);
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return GAIN_BITS'($urandom_range(1, 255));
            2:       return 16'h8000;
            3:       return '1;
            default: return GAIN_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [BASE_BITS-1:0] pick_table_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return BASE_BITS'($urandom_range(0, 24'h03FFFF));
            default: return BASE_BITS'($urandom());
        endcase
    endfunction

    // Recent addresses are favored so that reads follow their writes closely.
    function automatic logic [RAW_BITS-1:0] pick_loaded_addr();
        int n;
        n = loaded_addrs.size();
        if ($urandom_range(0, 2) == 0)
            return loaded_addrs[n - 1 - $urandom_range(0, (n > 4) ? 3 : n - 1)];
        return loaded_addrs[$urandom_range(0, n - 1)];
    endfunction

    task automatic run_random(int count);
        logic [RAW_BITS-1:0] raw;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                raw = ($urandom_range(0, 1) == 0) ? pick_loaded_addr() : RAW_BITS'($urandom());
                push_write(raw, pick_table_word());
            end else begin
                if (lut_on)
                    raw = pick_loaded_addr();
                else if ($urandom_range(0, 7) == 0)
                    raw = $urandom_range(0, 1) ? '1 : '0;
                else
                    raw = RAW_BITS'($urandom());
                push_pixel(raw, pick_gain());
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        lut_on = 1'b0;
        vig_on = 1'b0;

        // Reset settings: raw values pass through shifted up by eight bits, the gain is ignored.
        push_pixel(16'h0000, 16'h0000);
        push_pixel(16'hFFFF, 16'hFFFF);
        push_write(16'h0000, 24'h000000);
        push_write(16'hFFFF, 24'hFFFFFF);
        push_write(16'h0001, 24'h000001);
        push_write(16'h8000, 24'h800000);
        push_write(16'h1234, 24'h00ABCD);
        // These two sit on either side of the point where a unit gain overflows.
        push_write(16'h0002, 24'h01FFFF);
        push_write(16'h0003, 24'h020000);
        push_pixel(16'h5A5A, 16'h0001);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_UNUSED_LOW, 1'b1);
        write_reg(REG_UNUSED_HIGH, 1'b1);
        apply_settings(1'b1, 1'b1);

        push_pixel(16'hFFFF, 16'h0000);
        push_pixel(16'hFFFF, 16'h0001);
        push_pixel(16'h0000, 16'h0000);
        push_pixel(16'h0000, 16'h0001);
        push_pixel(16'h8000, 16'h8000);
        push_pixel(16'h0001, 16'hFFFF);
        push_pixel(16'h8000, 16'h0002);
        push_pixel(16'h1234, 16'h0080);
        push_pixel(16'h0002, 16'h0001);
        push_pixel(16'h0003, 16'h0001);

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       apply_settings(1'b0, 1'b0);
                1:       apply_settings(1'b1, 1'b0);
                2:       apply_settings(1'b0, 1'b1);
                3:       apply_settings(1'b1, 1'b1);
                default: apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            steady_sender = (phase == 3);
            run_random(RANDOM_HALF);
            // Let the pipe run dry once per phase before sending more.
            wait_results();
            run_random(RANDOM_HALF);
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Checked %0d pixel words (%0d saturated) and %0d table writes",
                 pixel_count, sat_count, write_count);
        $display("across %0d enable settings, with %0d mismatches.",
                 settings_count, mismatch_count);
        if (mismatch_count == 0 && expected_corrections.size() == 0) begin
            $display("photometric_pixel_correction_test: PASS");
        end else begin
            $display("photometric_pixel_correction_test: FAIL");
        end
        $finish;
    end

endmodule
